[rtl/scdf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scdf_pkg: shared types and constants of the salted checksum deframer
// Item layouts, result kinds and register indexes.
// ----------------------------------------------------------------------------
package scdf_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] frame_type;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic [10:0] payload_index;
        logic        last_of_frame;
    } result_item_t;

    // Result pushed by the front part toward the queue
    typedef struct packed {
        logic         valid;
        result_item_t item;
    } front_result_t;

    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_GOOD      = 3'd1;
    localparam logic [2:0] KIND_BAD_DELIM = 3'd2;
    localparam logic [2:0] KIND_BAD_SUM   = 3'd3;
    localparam logic [2:0] KIND_TOO_LONG  = 3'd4;

    localparam logic REG_DELIMITER = 1'b0;
    localparam logic REG_SALT      = 1'b1;

    localparam logic [31:0] DELIMITER_RESET = 32'h3AF9_02B1;
    localparam logic [15:0] SALT_RESET      = 16'hA35C;

    // Header is delimiter (4 bytes) plus type and length (2 bytes each)
    localparam int unsigned HEADER_BYTES = 8;
    // Header plus two checksum bytes
    localparam int unsigned OVERHEAD_BYTES = 10;

endpackage : scdf_pkg
`default_nettype wire

[rtl/scdf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scdf_front: byte classifier and frame tracker
// Places each accepted byte in the frame, runs the salted checksum, checks
// the header and forms at most one result for the byte.
// ----------------------------------------------------------------------------
module scdf_front
    import scdf_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 2048
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire byte_item_t    byte_item,
    input  wire logic [31:0]   delimiter_word,
    input  wire logic [15:0]   salt_value,
    output      front_result_t result
);

    // Highest position ever held is MAX_FRAME - 1
    localparam int unsigned POS_W = $clog2(MAX_FRAME);

    logic [POS_W-1:0] pos_reg,      pos_next;
    logic             mismatch_reg, mismatch_next;
    logic [15:0]      type_reg,     type_next;
    logic [15:0]      len_reg,      len_next;
    logic [15:0]      sum_reg,      sum_next;
    logic [7:0]       cks_hi_reg,   cks_hi_next;
    logic             skip_reg,     skip_next;

    logic [7:0]  b;
    logic        end_flag;
    logic [16:0] pos_ext;
    logic [16:0] pay_end;
    logic [16:0] pay_idx;
    logic [15:0] add_val;
    logic [15:0] mask_val;
    logic [15:0] sum_step;
    logic [7:0]  want;
    logic        in_head;

    assign b        = byte_item.data_byte;
    assign end_flag = byte_item.chunk_end;
    assign pos_ext  = 17'(pos_reg);
    assign pay_end  = {1'b0, len_reg} + 17'(HEADER_BYTES);
    assign pay_idx  = pos_ext - 17'(HEADER_BYTES);
    assign in_head  = pos_ext < 17'(HEADER_BYTES);

    // Odd positions add into the high byte
    assign add_val  = pos_reg[0] ? {8'(b + 8'd1), 8'h00} : ({8'h00, b} + 16'd1);
    assign mask_val = b[0] ? {salt_value[14:0], 1'b0} : {1'b0, salt_value[15:1]};
    assign sum_step = (sum_reg + add_val) ^ mask_val;

    always_comb
    begin
        unique case (pos_reg[1:0])
            2'd0:    want = delimiter_word[31:24];
            2'd1:    want = delimiter_word[23:16];
            2'd2:    want = delimiter_word[15:8];
            default: want = delimiter_word[7:0];
        endcase
    end

    always_comb
    begin
        pos_next      = pos_reg;
        mismatch_next = mismatch_reg;
        type_next     = type_reg;
        len_next      = len_reg;
        sum_next      = sum_reg;
        cks_hi_next   = cks_hi_reg;
        skip_next     = skip_reg;

        result                     = '0;
        result.item.frame_type     = type_reg;
        result.item.payload_length = len_reg;

        if (skip_reg)
        begin
            // Drop bytes up to and including the chunk end
            if (end_flag)
            begin
                skip_next = 1'b0;
            end
        end
        else if (in_head)
        begin
            sum_next = sum_step;
            pos_next = pos_reg + POS_W'(1);
            unique case (pos_reg[2:0])
                3'd0, 3'd1, 3'd2, 3'd3:
                begin
                    if (b != want)
                    begin
                        mismatch_next = 1'b1;
                    end
                end
                3'd4:    type_next = {b, type_reg[7:0]};
                3'd5:    type_next = {type_reg[15:8], b};
                3'd6:    len_next  = {b, len_reg[7:0]};
                default: len_next  = {len_reg[15:8], b};
            endcase

            if (pos_reg[2:0] == 3'd7)
            begin
                result.item.payload_length = len_next;
                if (mismatch_reg)
                begin
                    result.valid     = 1'b1;
                    result.item.kind = KIND_BAD_DELIM;
                end
                else if (({1'b0, len_next} + 17'(OVERHEAD_BYTES)) > 17'(MAX_FRAME))
                begin
                    result.valid     = 1'b1;
                    result.item.kind = KIND_TOO_LONG;
                end
                if (result.valid)
                begin
                    result.item.last_of_frame = 1'b1;
                    skip_next = !end_flag;
                end
            end
        end
        else if (pos_ext < pay_end)
        begin
            sum_next                  = sum_step;
            pos_next                  = pos_reg + POS_W'(1);
            result.valid              = 1'b1;
            result.item.kind          = KIND_PAYLOAD;
            result.item.payload_byte  = b;
            result.item.payload_index = pay_idx[10:0];
        end
        else if (pos_ext == pay_end)
        begin
            cks_hi_next = b;
            pos_next    = pos_reg + POS_W'(1);
        end
        else
        begin
            result.valid              = 1'b1;
            result.item.last_of_frame = 1'b1;
            if ({cks_hi_reg, b} == sum_reg)
            begin
                result.item.kind = KIND_GOOD;
            end
            else
            begin
                result.item.kind = KIND_BAD_SUM;
                skip_next        = !end_flag;
            end
        end

        // Any verdict restarts the frame
        if (result.valid && result.item.last_of_frame)
        begin
            pos_next      = '0;
            mismatch_next = 1'b0;
            type_next     = '0;
            len_next      = '0;
            sum_next      = '0;
            cks_hi_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            mismatch_reg <= 1'b0;
            type_reg     <= '0;
            len_reg      <= '0;
            sum_reg      <= '0;
            cks_hi_reg   <= '0;
            skip_reg     <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            mismatch_reg <= mismatch_next;
            type_reg     <= type_next;
            len_reg      <= len_next;
            sum_reg      <= sum_next;
            cks_hi_reg   <= cks_hi_next;
            skip_reg     <= skip_next;
        end
    end

    // Skipping only ever starts right after a verdict
    a_skip_at_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> (pos_reg == '0))
        else $error("skipping while inside a frame");

    // A delimiter mismatch cannot outlive the header
    a_mismatch_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        mismatch_reg |-> (pos_reg != '0 && pos_ext < 17'(HEADER_BYTES)))
        else $error("delimiter mismatch held outside the header");

    // A payload byte is never the frame closer
    a_payload_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.item.kind == KIND_PAYLOAD) |-> !result.item.last_of_frame)
        else $error("payload result flagged as last of frame");

    // After a verdict is taken, the next byte starts a new frame
    a_verdict_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.valid && result.item.last_of_frame) |=> (pos_reg == '0))
        else $error("frame position not cleared after verdict");

endmodule : scdf_front
`default_nettype wire

[rtl/scdf_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scdf_queue: two-entry result queue
// Holds results from the front part until the consumer takes them.
// ----------------------------------------------------------------------------
module scdf_queue
    import scdf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire result_item_t push_item,
    output      logic         full,
    output      logic         result_valid,
    input  wire logic         result_ready,
    output      result_item_t result_item
);

    result_item_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg,  count_next;
    logic         pop;

    assign full         = (count_reg == 2'd2);
    assign result_valid = (count_reg != 2'd0);
    assign result_item  = entry_reg[rd_ptr_reg];
    assign pop          = result_valid && result_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    // Pointers differ exactly when one entry is held
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg != rd_ptr_reg) == (count_reg == 2'd1))
        else $error("queue pointers disagree with count");

endmodule : scdf_queue
`default_nettype wire

[rtl/salted_checksum_frame_deframer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// salted_checksum_frame_deframer_unit: salted checksum frame deframer
// Cuts a byte stream into delimited frames, emits payload bytes and one
// verdict per frame, and skips the rest of a chunk after an error.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  byte      in   byte_valid / byte_ready    byte_item   (byte_item_t)
//  result    out  result_valid/result_ready  result_item (result_item_t)
//  cfg       in   cfg_we                     cfg_index, cfg_wdata
//
//  One byte per cycle; each byte is classified and folded into the checksum
//  in the cycle it is accepted, and its result is registered in the queue.
//  A two-entry queue sits between the tracker and the result port, so a
//  byte is accepted while a result waits; byte_ready drops only when full.
//  Reset clears the frame state and loads the register defaults.
// ----------------------------------------------------------------------------
module salted_checksum_frame_deframer_unit
    import scdf_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 2048
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    output      logic         byte_ready,
    input  wire byte_item_t   byte_item,
    output      logic         result_valid,
    input  wire logic         result_ready,
    output      result_item_t result_item,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    logic [31:0]   delimiter_reg, delimiter_next;
    logic [15:0]   salt_reg,      salt_next;
    logic          accept;
    logic          full;
    front_result_t front_res;

    assign byte_ready = !full;
    assign accept     = byte_valid && byte_ready;

    always_comb
    begin
        delimiter_next = delimiter_reg;
        salt_next      = salt_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DELIMITER: delimiter_next = cfg_wdata;
                default:       salt_next      = cfg_wdata[15:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIMITER_RESET;
            salt_reg      <= SALT_RESET;
        end
        else
        begin
            delimiter_reg <= delimiter_next;
            salt_reg      <= salt_next;
        end
    end

    scdf_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .byte_item      (byte_item),
        .delimiter_word (delimiter_reg),
        .salt_value     (salt_reg),
        .result         (front_res)
    );

    scdf_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept && front_res.valid),
        .push_item    (front_res.item),
        .full         (full),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule : salted_checksum_frame_deframer_unit
`default_nettype wire
